// ===== hw/rtl/nmea_sentence_framer_checker_top_defines.svh =====
// Assertion macros shared by the sentence framer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_TOP_DEFINES_SVH

// Checked on every rising edge of aclk while reset is released.
`define NFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define NFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/nfc_pkg.sv =====
// Shared types, codes and helper functions of the NMEA sentence framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nfc_pkg;

    // Register map (word indices, taken from paddr[3:2]).
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_START_CHAR = 2'd0;
    localparam logic [1:0] REG_END_PAIR   = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

    localparam logic [7:0]  START_CHAR_RST = 8'd36;
    localparam logic [15:0] END_PAIR_RST   = 16'd3338;
    localparam logic [7:0]  MAX_LENGTH_RST = 8'd100;

    // Result status codes.
    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERLEN  = 2'd2;

    // Sentence type codes.
    localparam logic [2:0] TYPE_OTHER = 3'd0;
    localparam logic [2:0] TYPE_GPRMC = 3'd1;
    localparam logic [2:0] TYPE_GPHDT = 3'd2;
    localparam logic [2:0] TYPE_PRDID = 3'd3;
    localparam logic [2:0] TYPE_PSBGI = 3'd4;

    // Checksum collection phases.
    localparam logic [1:0] STAR_NONE = 2'd0;
    localparam logic [1:0] STAR_HI   = 2'd1;
    localparam logic [1:0] STAR_LO   = 2'd2;
    localparam logic [1:0] STAR_DONE = 2'd3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;

    localparam int unsigned NUM_TYPES = 4;
    localparam int unsigned NAME_LEN  = 5;

    // Talker plus sentence names, one row per candidate bit.
    localparam logic [7:0] TYPE_NAMES [NUM_TYPES][NAME_LEN] = '{
        '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
        '{8'h47, 8'h50, 8'h48, 8'h44, 8'h54},
        '{8'h50, 8'h52, 8'h44, 8'h49, 8'h44},
        '{8'h50, 8'h53, 8'h42, 8'h47, 8'h49}
    };

    typedef struct packed {
        logic [7:0]  start_char;
        logic [15:0] end_pair;
        logic [7:0]  max_length;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [2:0] sentence_type;
        logic       fix_valid;
        logic [7:0] sentence_length;
    } res_t;

    // Hex digit conversion with no range check, modulo 256.
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        return (c >= CH_A) ? (c - 8'd55) : (c - 8'd48);
    endfunction

endpackage

// ===== hw/rtl/nmea_sentence_framer_checker_top.sv =====
// Top level of the NMEA 0183 sentence framer and checksum checker.
// Depends on nfc_pkg, nfc_cfg_regs, nfc_parse_core and the assertion macros header.
`timescale 1ns / 1ps
`include "nmea_sentence_framer_checker_top_defines.svh"

// The block takes one received byte per input beat and returns one result beat
// per finished sentence: a sentence ends on the configured end pair, or is
// dropped with status 2 once its character count reaches max_length. A byte is
// taken every clock cycle while s_ready is high; all framing, checksum and type state
// is updated by one pass of logic from the byte and the state registers, so throughput
// is then one byte per cycle and a result shows on the m_ ports in the cycle after the
// closing byte if the output register is free or read. Results pass through an output
// register backed by a one-entry skid register, so s_ready stays high while a single
// result waits on m_ready and only drops once both entries hold a result. Configuration
// is written through the APB port at byte addresses 0 (start_char), 4 (end_pair) and 8
// (max_length) and should only change while the block is idle.

module nmea_sentence_framer_checker_top
    import nfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_in,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [2:0]        m_sentence_type,
    output logic              m_fix_valid,
    output logic [7:0]        m_sentence_length
);

    cfg_t cfg;
    res_t res;
    res_t out_reg;
    res_t skid_reg;
    logic in_accept;
    logic pop;

    nfc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input beats are refused only when both result slots are occupied.
    assign s_ready   = !skid_reg.valid;
    assign in_accept = s_valid && s_ready;

    nfc_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .byte_in   (s_byte_in),
        .res       (res)
    );

    assign pop = out_reg.valid && m_ready;

    // The output register is refilled from the skid register first; a new
    // result lands in the skid register only when the output slot stays busy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid  <= 1'b0;
            skid_reg.valid <= 1'b0;
        end else begin
            if (skid_reg.valid) begin
                if (pop) begin
                    out_reg        <= skid_reg;
                    skid_reg.valid <= 1'b0;
                end
            end else if (res.valid) begin
                if (!out_reg.valid || pop) begin
                    out_reg <= res;
                end else begin
                    skid_reg <= res;
                end
            end else if (pop) begin
                out_reg.valid <= 1'b0;
            end
        end
    end

    assign m_valid           = out_reg.valid;
    assign m_status          = out_reg.status;
    assign m_sentence_type   = out_reg.sentence_type;
    assign m_fix_valid       = out_reg.fix_valid;
    assign m_sentence_length = out_reg.sentence_length;

    // The skid slot only fills behind a waiting output beat.
    `NFC_ASSERT(a_skid_behind_out, skid_reg.valid |-> out_reg.valid, "skid full while output empty")
    // Discarded sentences carry no type and no fix.
    `NFC_ASSERT(a_overlen_fields, (m_valid && m_status == ST_OVERLEN) |-> (m_sentence_type == TYPE_OTHER && !m_fix_valid), "overlength result with type or fix")
    // A fix is only reported for a recognized GPRMC sentence.
    `NFC_ASSERT(a_fix_gprmc, (m_valid && m_fix_valid) |-> m_sentence_type == TYPE_GPRMC, "fix_valid on non-GPRMC sentence")
    // Reset empties both result slots.
    `NFC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid && s_ready), "result slots not empty after reset")

endmodule

// ===== hw/rtl/nfc_cfg_regs.sv =====
// APB-style configuration register file of the sentence framer.
// Depends on nfc_pkg for the register map and the cfg_t type.
`timescale 1ns / 1ps

module nfc_cfg_regs
    import nfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char <= START_CHAR_RST;
            cfg_reg.end_pair   <= END_PAIR_RST;
            cfg_reg.max_length <= MAX_LENGTH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_CHAR: cfg_reg.start_char <= pwdata[7:0];
                REG_END_PAIR:   cfg_reg.end_pair   <= pwdata[15:0];
                REG_MAX_LENGTH: cfg_reg.max_length <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_CHAR: prdata = {24'd0, cfg_reg.start_char};
            REG_END_PAIR:   prdata = {16'd0, cfg_reg.end_pair};
            REG_MAX_LENGTH: prdata = {24'd0, cfg_reg.max_length};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/nfc_parse_core.sv =====
// Per-byte framing, checksum and sentence-type state of the framer.
// Depends on nfc_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "nmea_sentence_framer_checker_top_defines.svh"

module nfc_parse_core
    import nfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_accept,
    input  logic [7:0] byte_in,
    output res_t       res
);

    logic       in_sentence_reg, in_sentence_next;
    logic [7:0] char_count_reg, char_count_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [1:0] star_phase_reg, star_phase_next;
    logic [7:0] received_sum_reg, received_sum_next;
    logic       prev_end_reg, prev_end_next;
    logic [3:0] field_number_reg, field_number_next;
    logic [3:0] type_cand_reg, type_cand_next;
    logic [1:0] status_chars_reg, status_chars_next;
    logic       status_is_a_reg, status_is_a_next;
    res_t       res_next;

    always_comb begin
        logic [7:0] pos;
        logic [2:0] name_idx;
        logic       ended;
        logic [2:0] stype;
        logic [7:0] digit;

        in_sentence_next  = in_sentence_reg;
        char_count_next   = char_count_reg;
        running_xor_next  = running_xor_reg;
        star_phase_next   = star_phase_reg;
        received_sum_next = received_sum_reg;
        prev_end_next     = prev_end_reg;
        field_number_next = field_number_reg;
        type_cand_next    = type_cand_reg;
        status_chars_next = status_chars_reg;
        status_is_a_next  = status_is_a_reg;
        res_next          = '0;
        pos               = char_count_reg;
        name_idx          = pos[2:0] - 3'd1;
        ended             = 1'b0;
        stype             = TYPE_OTHER;
        digit             = hex_digit(byte_in);

        if (!in_sentence_reg) begin
            if (byte_in == cfg.start_char) begin
                in_sentence_next  = 1'b1;
                char_count_next   = 8'd1;
                running_xor_next  = 8'd0;
                star_phase_next   = STAR_NONE;
                received_sum_next = 8'd0;
                prev_end_next     = 1'b0;
                field_number_next = 4'd0;
                type_cand_next    = (byte_in == CH_DOLLAR) ? 4'hF : 4'h0;
                status_chars_next = 2'd0;
                status_is_a_next  = 1'b0;
            end
        end else begin
            if (char_count_reg != 8'hFF) begin
                char_count_next = char_count_reg + 8'd1;
            end

            case (star_phase_reg)
                STAR_NONE: begin
                    if (byte_in == CH_STAR) begin
                        star_phase_next = STAR_HI;
                    end else begin
                        running_xor_next = running_xor_reg ^ byte_in;
                    end
                end
                STAR_HI: begin
                    received_sum_next = {digit[3:0], 4'd0};
                    star_phase_next   = STAR_LO;
                end
                STAR_LO: begin
                    received_sum_next = received_sum_reg + digit;
                    star_phase_next   = STAR_DONE;
                end
                default: ;
            endcase

            // Type name lives in bytes one to five and a comma must follow.
            if (pos >= 8'd1 && pos <= 8'd5) begin
                for (int k = 0; k < NUM_TYPES; k++) begin
                    if (byte_in != TYPE_NAMES[k][name_idx]) begin
                        type_cand_next[k] = 1'b0;
                    end
                end
            end else if (pos == 8'd6 && byte_in != CH_COMMA) begin
                type_cand_next = 4'h0;
            end

            if (byte_in == CH_COMMA) begin
                if (field_number_reg == 4'd2) begin
                    status_is_a_next = status_is_a_reg && (status_chars_reg == 2'd1);
                end
                if (field_number_reg != 4'd15) begin
                    field_number_next = field_number_reg + 4'd1;
                end
            end else if (field_number_reg == 4'd2) begin
                if (status_chars_reg == 2'd0) begin
                    status_is_a_next = (byte_in == CH_A);
                end
                if (status_chars_reg != 2'd3) begin
                    status_chars_next = status_chars_reg + 2'd1;
                end
            end

            ended         = prev_end_reg && (byte_in == cfg.end_pair[7:0]);
            prev_end_next = (byte_in == cfg.end_pair[15:8]);

            if (field_number_next != 4'd0) begin
                if (type_cand_next[0]) begin
                    stype = TYPE_GPRMC;
                end else if (type_cand_next[1]) begin
                    stype = TYPE_GPHDT;
                end else if (type_cand_next[2]) begin
                    stype = TYPE_PRDID;
                end else if (type_cand_next[3]) begin
                    stype = TYPE_PSBGI;
                end
            end

            if (ended) begin
                res_next.valid  = 1'b1;
                res_next.status = (star_phase_next == STAR_DONE
                                   && received_sum_next == running_xor_next)
                                  ? ST_MATCH : ST_MISMATCH;
                res_next.sentence_type   = stype;
                res_next.fix_valid       = (stype == TYPE_GPRMC)
                                           && (field_number_next >= 4'd3)
                                           && status_is_a_next;
                res_next.sentence_length = char_count_next;
                in_sentence_next         = 1'b0;
            end else if (char_count_next >= cfg.max_length) begin
                res_next.valid           = 1'b1;
                res_next.status          = ST_OVERLEN;
                res_next.sentence_type   = TYPE_OTHER;
                res_next.fix_valid       = 1'b0;
                res_next.sentence_length = char_count_next;
                in_sentence_next         = 1'b0;
            end
        end
    end

    assign res       = res_next & {$bits(res_t){in_accept}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg  <= 1'b0;
            char_count_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            star_phase_reg   <= STAR_NONE;
            received_sum_reg <= 8'd0;
            prev_end_reg     <= 1'b0;
            field_number_reg <= 4'd0;
            type_cand_reg    <= 4'h0;
            status_chars_reg <= 2'd0;
            status_is_a_reg  <= 1'b0;
        end else if (in_accept) begin
            in_sentence_reg  <= in_sentence_next;
            char_count_reg   <= char_count_next;
            running_xor_reg  <= running_xor_next;
            star_phase_reg   <= star_phase_next;
            received_sum_reg <= received_sum_next;
            prev_end_reg     <= prev_end_next;
            field_number_reg <= field_number_next;
            type_cand_reg    <= type_cand_next;
            status_chars_reg <= status_chars_next;
            status_is_a_reg  <= status_is_a_next;
        end
    end

    // Every open sentence holds at least its start byte.
    `NFC_ASSERT(a_open_count, in_sentence_reg |-> char_count_reg != 8'd0, "open sentence with zero count")
    // A reported sentence is closed by the same beat.
    `NFC_ASSERT(a_result_closes, res.valid |=> !in_sentence_reg, "sentence still open after result")

endmodule
